// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent check, clocked on clk_i and quiet while rst_ni is low.
`define BPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bit plane shuffle check failed");

// Check that also runs while reset is asserted.
`define BPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("bit plane shuffle check failed");

`endif

// ----- hw/rtl/bps_pkg.sv -----
`timescale 1ns / 1ps
package bps_pkg;

  localparam int MAX_ELEM_BYTES = 8;
  localparam int PLANES_MAX     = 8 * MAX_ELEM_BYTES;
  localparam int PLANE_IDX_W    = $clog2(PLANES_MAX);

  localparam int ELEM_W  = 64;
  localparam int ADDR_W  = 35;
  localparam int CFG_W   = 32;
  localparam int BPP_W   = 30;
  localparam int GROUP_W = 29;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_COUNT = 2'd1;

  localparam logic [3:0]       ELEM_BYTES_RESET = 4'd4;
  localparam logic [CFG_W-1:0] ELEM_COUNT_RESET = 32'd1;

  // Run queue between the front and the back.
  localparam int RUN_FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W     = (RUN_FIFO_DEPTH > 1) ? $clog2(RUN_FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W     = $clog2(RUN_FIFO_DEPTH + 1);

  // One complete group of plane bytes, ready to be emitted.
  typedef struct packed {
    logic [PLANES_MAX-1:0][7:0] planes;
    logic [PLANE_IDX_W-1:0]     last_plane;
    logic [BPP_W-1:0]           bpp;
    logic [GROUP_W-1:0]         group;
    logic                       block_last;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- hw/rtl/bps_front.sv -----
`timescale 1ns / 1ps
module bps_front import bps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [ELEM_W-1:0]    elem_value_i,
  input  logic                 elem_valid_i,
  output logic                 elem_stall_o,
  input  fifo_stat_t           fifo_stat_i,
  output logic                 push_o,
  output run_t                 run_o
);

  logic [3:0]                 elem_bytes_q, elem_bytes_d;
  logic [CFG_W-1:0]           elem_count_q, elem_count_d;
  logic [CFG_W-1:0]           idx_q, idx_d;
  logic [PLANES_MAX-1:0][7:0] acc_q, acc_d;

  logic [3:0]       eff_bytes;
  logic [6:0]       nplanes;
  logic [CFG_W-1:0] eff_count;
  logic [CFG_W:0]   bpp_sum;
  logic [2:0]       slot;
  logic             last;
  logic             run_due;
  logic             accept;
  logic [PLANES_MAX-1:0][7:0] gathered;

  always_comb begin
    if (elem_bytes_q == 4'd0) begin
      eff_bytes = 4'd1;
    end else if (elem_bytes_q > 4'(MAX_ELEM_BYTES)) begin
      eff_bytes = 4'(MAX_ELEM_BYTES);
    end else begin
      eff_bytes = elem_bytes_q;
    end
  end

  assign nplanes   = {eff_bytes, 3'b000};
  assign eff_count = (elem_count_q == '0) ? CFG_W'(1) : elem_count_q;
  assign bpp_sum   = {1'b0, eff_count} + (CFG_W+1)'(7);
  assign slot      = idx_q[2:0];
  assign last      = ({1'b0, idx_q} + (CFG_W+1)'(1)) >= {1'b0, eff_count};
  assign run_due   = (slot == 3'd7) || last;

  // Only an element that closes a group needs room in the run queue.
  assign elem_stall_o = run_due && fifo_stat_i.full;
  assign accept       = elem_valid_i && !elem_stall_o;
  assign push_o       = accept && run_due;

  always_comb begin
    for (int p = 0; p < PLANES_MAX; p++) begin
      gathered[p] = acc_q[p];
      if ((7'(p) < nplanes) && elem_value_i[p]) begin
        gathered[p] = acc_q[p] | (8'd1 << slot);
      end
    end
  end

  always_comb begin
    run_o.planes     = gathered;
    run_o.last_plane = PLANE_IDX_W'(nplanes - 7'd1);
    run_o.bpp        = bpp_sum[CFG_W:3];
    run_o.group      = idx_q[CFG_W-1:3];
    run_o.block_last = last;
  end

  always_comb begin
    idx_d = idx_q;
    acc_d = acc_q;
    if (accept) begin
      idx_d = last ? '0 : idx_q + CFG_W'(1);
      acc_d = run_due ? '0 : gathered;
    end
  end

  always_comb begin
    elem_bytes_d = elem_bytes_q;
    elem_count_d = elem_count_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ELEM_BYTES: elem_bytes_d = cfg_data_i[3:0];
        CFG_ELEM_COUNT: elem_count_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_bytes_q <= ELEM_BYTES_RESET;
      elem_count_q <= ELEM_COUNT_RESET;
      idx_q        <= '0;
      acc_q        <= '0;
    end else begin
      elem_bytes_q <= elem_bytes_d;
      elem_count_q <= elem_count_d;
      idx_q        <= idx_d;
      acc_q        <= acc_d;
    end
  end

endmodule

// ----- hw/rtl/bps_run_fifo.sv -----
`timescale 1ns / 1ps
module bps_run_fifo import bps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  run_t       data_i,
  input  logic       pop_i,
  output run_t       data_o,
  output fifo_stat_t stat_o
);

  run_t                  mem_q [RUN_FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign stat_o.full  = (cnt_q == FIFO_CNT_W'(RUN_FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(RUN_FIFO_DEPTH - 1)) ? '0
                                                               : wr_ptr_q + FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(RUN_FIFO_DEPTH - 1)) ? '0
                                                               : rd_ptr_q + FIFO_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/bps_back.sv -----
`timescale 1ns / 1ps
module bps_back import bps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  run_t              head_i,
  input  fifo_stat_t        fifo_stat_i,
  output logic              pop_o,
  output logic [ADDR_W-1:0] res_byte_address_o,
  output logic [7:0]        res_byte_value_o,
  output logic              res_run_last_o,
  output logic              res_block_end_o,
  output logic              res_valid_o,
  input  logic              res_stall_i
);

  logic [PLANE_IDX_W-1:0] plane_q, plane_d;
  logic [ADDR_W-1:0]      next_addr_q, next_addr_d;
  logic                   valid_q, valid_d;
  logic [ADDR_W-1:0]      addr_q, addr_d;
  logic [7:0]             value_q, value_d;
  logic                   run_last_q, run_last_d;
  logic                   block_end_q, block_end_d;
  logic                   load;
  logic                   plane_last;

  assign load       = !fifo_stat_i.empty && (!valid_q || !res_stall_i);
  assign plane_last = (plane_q == head_i.last_plane);
  assign pop_o      = load && plane_last;

  always_comb begin
    plane_d     = plane_q;
    next_addr_d = next_addr_q;
    valid_d     = valid_q && res_stall_i;
    addr_d      = addr_q;
    value_d     = value_q;
    run_last_d  = run_last_q;
    block_end_d = block_end_q;
    if (load) begin
      // The address walks by one plane stride per emitted byte.
      addr_d      = (plane_q == '0) ? ADDR_W'(head_i.group) : next_addr_q;
      next_addr_d = addr_d + ADDR_W'(head_i.bpp);
      value_d     = head_i.planes[plane_q];
      run_last_d  = plane_last;
      block_end_d = head_i.block_last;
      valid_d     = 1'b1;
      plane_d     = plane_last ? '0 : plane_q + PLANE_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    next_addr_q <= next_addr_d;
    addr_q      <= addr_d;
    value_q     <= value_d;
    run_last_q  <= run_last_d;
    block_end_q <= block_end_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
      valid_q <= 1'b0;
    end else begin
      plane_q <= plane_d;
      valid_q <= valid_d;
    end
  end

  assign res_valid_o        = valid_q;
  assign res_byte_address_o = addr_q;
  assign res_byte_value_o   = value_q;
  assign res_run_last_o     = run_last_q;
  assign res_block_end_o    = block_end_q;

endmodule

// ----- hw/rtl/bit_plane_shuffle_encoder.sv -----
`timescale 1ns / 1ps
// Bit-plane shuffle encoder. Elements enter on the elem channel, one per
// transaction, and plane bytes leave on the res channel with their byte
// offset in the shuffled block, a run_last flag on the last plane of a
// group and a block_end flag on every byte of the run that ends a block.
// The front gathers each element into 64 plane bytes and takes one element
// per cycle unless it stalls. When an element closes a group of eight or
// ends the block, the finished group is pushed into a two-entry run queue.
// The back drains the head run at one plane byte per cycle while res does
// not stall, and the queue lets the front take further elements meanwhile.
// A block that ends in a partial group still emits a whole run of
// 8*elem_bytes planes, so with elem_count of 1 every element yields a whole
// run. When the back is idle, the run of the closing element is written into
// the queue and its first byte is loaded from there into the output register.
// The front stalls only when an element would close a group or end the block
// while the queue is full. A stall on res holds the output register; the
// queue absorbs the next runs meanwhile. Configuration writes take effect at
// the next edge. Reset clears the gather buffer, the element index and the
// queue, and sets elem_bytes to 4 and elem_count to 1.
`include "assert_macros.svh"
module bit_plane_shuffle_encoder import bps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [ELEM_W-1:0]    elem_value_i,
  input  logic                 elem_valid_i,
  output logic                 elem_stall_o,
  output logic [ADDR_W-1:0]    res_byte_address_o,
  output logic [7:0]           res_byte_value_o,
  output logic                 res_run_last_o,
  output logic                 res_block_end_o,
  output logic                 res_valid_o,
  input  logic                 res_stall_i
);

  fifo_stat_t fifo_stat;
  logic       push;
  logic       pop;
  run_t       run_in;
  run_t       run_head;

  // Front: configuration registers, element index and gather buffer.
  bps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .elem_value_i (elem_value_i),
    .elem_valid_i (elem_valid_i),
    .elem_stall_o (elem_stall_o),
    .fifo_stat_i  (fifo_stat),
    .push_o       (push),
    .run_o        (run_in)
  );

  // Queue of complete groups waiting to be emitted.
  bps_run_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (run_in),
    .pop_i  (pop),
    .data_o (run_head),
    .stat_o (fifo_stat)
  );

  // Back: walks the planes of the head run into the output register.
  bps_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (run_head),
    .fifo_stat_i        (fifo_stat),
    .pop_o              (pop),
    .res_byte_address_o (res_byte_address_o),
    .res_byte_value_o   (res_byte_value_o),
    .res_run_last_o     (res_run_last_o),
    .res_block_end_o    (res_block_end_o),
    .res_valid_o        (res_valid_o),
    .res_stall_i        (res_stall_i)
  );

  // The front only holds off elements when the run queue has no room.
  `BPS_ASSERT(a_stall_needs_full, elem_stall_o |-> fifo_stat.full)
  // Inside a run the next plane byte follows right after each transaction.
  `BPS_ASSERT(a_run_continues,
              (res_valid_o && !res_stall_i && !res_run_last_o) |=> res_valid_o)
  // The queue is never reported full and empty together.
  `BPS_ASSERT(a_fifo_stat_sane, !(fifo_stat.full && fifo_stat.empty))

endmodule

// ----- tb/bit_plane_shuffle_checker.sv -----
`timescale 1ns / 1ps
module bit_plane_shuffle_checker import bps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [ELEM_W-1:0]    elem_value_i,
  input  logic                 elem_valid_i,
  input  logic                 elem_stall_i,
  input  logic [ADDR_W-1:0]    res_byte_address_i,
  input  logic [7:0]           res_byte_value_i,
  input  logic                 res_run_last_i,
  input  logic                 res_block_end_i,
  input  logic                 res_valid_i,
  input  logic                 res_stall_i,
  output int unsigned          mismatches_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [7:0]        value;
    logic              run_last;
    logic              block_end;
  } plane_byte_t;

  logic [3:0]       elem_bytes;
  logic [CFG_W-1:0] elem_count;
  logic [7:0]       plane_bits [PLANES_MAX];
  logic [31:0]      element_index;
  plane_byte_t      expected_bytes [$];
  int unsigned      mismatches;

  assign mismatches_o = mismatches;

  initial mismatches = 0;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Spreads the bits of one element over the plane bytes and, when the
  // element closes a group or the block, queues the bytes of the group.
  task automatic absorb_element(input logic [ELEM_W-1:0] v);
    int unsigned nbytes;
    int unsigned nplanes;
    logic [32:0] n;
    logic [32:0] bpp;
    logic [2:0]  slot;
    logic        closes_block;
    logic [63:0] addr;
    plane_byte_t pb;
    nbytes = (elem_bytes == 0) ? 1 :
             (elem_bytes > MAX_ELEM_BYTES) ? MAX_ELEM_BYTES : elem_bytes;
    nplanes = 8 * nbytes;
    n = (elem_count == 0) ? 33'd1 : {1'b0, elem_count};
    slot = element_index[2:0];
    for (int p = 0; p < nplanes; p++) begin
      if (v[p]) plane_bits[p][slot] = 1'b1;
    end
    closes_block = ({1'b0, element_index} + 33'd1) >= n;
    if (slot == 3'd7 || closes_block) begin
      bpp = (n + 33'd7) >> 3;
      for (int p = 0; p < nplanes; p++) begin
        addr = 64'(p) * 64'(bpp) + 64'(element_index >> 3);
        pb.address = addr[ADDR_W-1:0];
        pb.value = plane_bits[p];
        pb.run_last = (p + 1 == nplanes);
        pb.block_end = closes_block;
        expected_bytes.push_back(pb);
      end
      for (int p = 0; p < PLANES_MAX; p++) plane_bits[p] = 8'h00;
      element_index = closes_block ? 32'd0 : element_index + 32'd1;
    end else begin
      element_index = element_index + 32'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    plane_byte_t want;
    if (!rst_ni) begin
      elem_bytes = ELEM_BYTES_RESET;
      elem_count = ELEM_COUNT_RESET;
      for (int p = 0; p < PLANES_MAX; p++) plane_bits[p] = 8'h00;
      element_index = 32'd0;
      expected_bytes.delete();
      pending_o <= 0;
    end else begin
      if (res_valid_i && !res_stall_i) begin
        if (expected_bytes.size() == 0) begin
          flag_mismatch("plane byte with nothing expected, address",
                        64'(res_byte_address_i), 64'd0);
        end else begin
          want = expected_bytes.pop_front();
          if (res_byte_address_i !== want.address)
            flag_mismatch("byte_address", 64'(res_byte_address_i), 64'(want.address));
          if (res_byte_value_i !== want.value)
            flag_mismatch("byte_value", 64'(res_byte_value_i), 64'(want.value));
          if (res_run_last_i !== want.run_last)
            flag_mismatch("run_last", 64'(res_run_last_i), 64'(want.run_last));
          if (res_block_end_i !== want.block_end)
            flag_mismatch("block_end", 64'(res_block_end_i), 64'(want.block_end));
        end
      end
      // An element taken at the same edge as a write still sees the old setting.
      if (elem_valid_i && !elem_stall_i) absorb_element(elem_value_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ELEM_BYTES: elem_bytes = cfg_data_i[3:0];
          CFG_ELEM_COUNT: elem_count = cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= expected_bytes.size();
    end
  end

endmodule

// ----- tb/tb_bit_plane_shuffle_encoder.sv -----
`timescale 1ns / 1ps
module tb_bit_plane_shuffle_encoder;
  import bps_pkg::*;

  // Cycles to let pass once nothing is expected before a register write, so
  // that an element still in the gather stage has settled.
  localparam int SETTLE_CYCLES = 8;
  // At the end a full run of 64 planes plus the pipeline delay could still
  // show up if the block produced something it should not have.
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 500;
  // Slowest legal run: every element closes a 64-plane run and every plane
  // byte waits out the longest stall of full idle mode; taken four times.
  localparam longint RUN_LIMIT_NS = 64'd60_000_000;

  // Register indexes that do not exist in the block; writes must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic [ELEM_W-1:0]    elem_value_i = '0;
  logic                 elem_valid_i = 1'b0;
  logic                 elem_stall_o;
  logic [ADDR_W-1:0]    res_byte_address_o;
  logic [7:0]           res_byte_value_o;
  logic                 res_run_last_o;
  logic                 res_block_end_o;
  logic                 res_valid_o;
  logic                 res_stall_i = 1'b0;

  int unsigned mismatches;
  int unsigned pending;
  idle_mode_e  send_mode = IDLE_NONE;
  idle_mode_e  recv_mode = IDLE_NONE;
  int          res_wait = 0;

  always #10 clk_i = ~clk_i;

  bit_plane_shuffle_encoder uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .elem_value_i       (elem_value_i),
    .elem_valid_i       (elem_valid_i),
    .elem_stall_o       (elem_stall_o),
    .res_byte_address_o (res_byte_address_o),
    .res_byte_value_o   (res_byte_value_o),
    .res_run_last_o     (res_run_last_o),
    .res_block_end_o    (res_block_end_o),
    .res_valid_o        (res_valid_o),
    .res_stall_i        (res_stall_i)
  );

  // The checker sits beside the block, watches both channels and the
  // register port, and reports how many plane bytes are still owed.
  bit_plane_shuffle_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .elem_value_i       (elem_value_i),
    .elem_valid_i       (elem_valid_i),
    .elem_stall_i       (elem_stall_o),
    .res_byte_address_i (res_byte_address_o),
    .res_byte_value_i   (res_byte_value_o),
    .res_run_last_i     (res_run_last_o),
    .res_block_end_i    (res_block_end_o),
    .res_valid_i        (res_valid_o),
    .res_stall_i        (res_stall_i),
    .mismatches_o       (mismatches),
    .pending_o          (pending)
  );

  // Number of idle cycles for one transaction. Light mode keeps the pipe
  // nearly full, full mode spreads gaps over every phase of a run.
  function automatic int draw_wait(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return $urandom_range(0, 2);
      default:    return $urandom_range(0, 18);
    endcase
  endfunction

  // Receiver side. After each accepted plane byte a new stall length is
  // drawn; the countdown runs whether or not a byte is on offer, so stalls
  // also land in the gaps between runs and on the first byte of a run.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_wait = 0;
      res_stall_i <= 1'b0;
    end else begin
      if (res_valid_o && !res_stall_i) begin
        res_wait = draw_wait(recv_mode);
      end else if (res_wait > 0) begin
        res_wait--;
      end
      res_stall_i <= (res_wait > 0);
    end
  end

  // One register write. The enable is held for a single cycle, and the task
  // returns only after it has been dropped, so that back to back writes never assign it twice in the same time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one element and returns at the edge where the transaction is
  // taken. Valid stays high into the next element when no gap is drawn.
  task automatic send_elem(input logic [ELEM_W-1:0] v);
    int gap;
    gap = draw_wait(send_mode);
    if (gap > 0) begin
      elem_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    elem_value_i <= v;
    elem_valid_i <= 1'b1;
    do @(posedge clk_i); while (elem_stall_o);
  endtask

  // Holds the sender back until every owed plane byte has arrived, then
  // lets the given number of extra cycles pass. The checker's count is
  // registered and lags a transaction, hence the first edge before looking at it.
  task automatic wait_idle(input int extra);
    elem_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int          phase_len;
    logic [ELEM_W-1:0] v;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Reset settings: four bytes, every element is a block;
    // the upper half of each element must be dropped.
    send_elem(64'hFFFF_FFFF_FFFF_FFFF);
    send_elem(64'h0000_0000_0000_0000);
    send_elem(64'h0123_4567_89AB_CDEF);
    wait_idle(SETTLE_CYCLES);

    // Widest element and an element count of zero, which acts as one.
    write_reg(CFG_ELEM_BYTES, 32'd8);
    write_reg(CFG_ELEM_COUNT, 32'd0);
    send_elem(64'hFFFF_FFFF_FFFF_FFFF);
    send_elem(64'hAAAA_AAAA_AAAA_AAAA);
    send_elem(64'h5555_5555_5555_5555);
    wait_idle(SETTLE_CYCLES);

    // A byte count of zero acts as one; ten elements give a full group and
    // then a partial one that ends the block with zero padding.
    write_reg(CFG_ELEM_BYTES, 32'd0);
    write_reg(CFG_ELEM_COUNT, 32'd10);
    for (int i = 0; i < 10; i++) send_elem(64'hDEAD_BEEF_0000_0000 | (64'h1 << i));
    wait_idle(SETTLE_CYCLES);

    // A byte count above eight acts as eight, with the largest block size,
    // so five elements leave a partial group and produce nothing.
    write_reg(CFG_ELEM_BYTES, 32'd15);
    write_reg(CFG_ELEM_COUNT, 32'hFFFF_FFFF);
    for (int i = 0; i < 5; i++) send_elem({$urandom, $urandom});
    wait_idle(SETTLE_CYCLES);

    // Now shrink both registers in the middle of the group. The count drops
    // below the element index, so the next element ends the block at once
    // and only the planes of the new byte count come out. The writes to the
    // nonexistent registers must leave everything as it is.
    write_reg(CFG_ELEM_BYTES, 32'd2);
    write_reg(CFG_ELEM_COUNT, 32'd3);
    write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);
    send_elem(64'hFFFF_FFFF_FFFF_FFFF);
    wait_idle(SETTLE_CYCLES);

    // Random part, in phases. Each phase may rewrite the registers while the
    // block is idle (often in the middle of a group or a block), picks its
    // own idle modes and then streams a batch of elements. Block sizes are
    // mostly small so that blocks end often and addresses wrap through
    // several groups; now and then the count is huge or out of range.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 7) < 6) write_reg(CFG_ELEM_BYTES, $urandom_range(1, 8));
        else write_reg(CFG_ELEM_BYTES, $urandom);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       write_reg(CFG_ELEM_COUNT, 32'd0);
          1:       write_reg(CFG_ELEM_COUNT, $urandom);
          2:       write_reg(CFG_ELEM_COUNT, 32'hFFFF_FFFF);
          default: write_reg(CFG_ELEM_COUNT, $urandom_range(1, 40));
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
      end
      send_mode = idle_mode_e'($urandom_range(0, 2));
      recv_mode = idle_mode_e'($urandom_range(0, 2));
      phase_len = $urandom_range(4, 40);
      for (int i = 0; i < phase_len; i++) begin
        case ($urandom_range(0, 7))
          0:       v = '1;
          1:       v = '0;
          2:       v = 64'h1 << $urandom_range(0, 63);
          default: v = {$urandom, $urandom};
        endcase
        send_elem(v);
      end
      sent += phase_len;
      wait_idle(SETTLE_CYCLES);
    end

    wait_idle(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
